FILE: hw/rtl/ami_pkg.sv
// ----------------------------------------------------------------------------
// ami_pkg: shared constants and types
// Defaults, the singular gain and the control structs used between the
// front, queue and back of the affine matrix inverse.
// ----------------------------------------------------------------------------
package ami_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // gain that stands in for 1/det when the determinant is zero
    localparam int GAIN_BITS = 24;
    localparam logic [GAIN_BITS-1:0] SINGULAR_GAIN = 24'd10000000;

    localparam int QUEUE_DEPTH = 2;
    localparam int N_ELEM      = 12;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef struct packed {
        logic singular;
        logic trans;
    } t_lane_ctrl;

endpackage

FILE: hw/rtl/ami_in_if.sv
// ----------------------------------------------------------------------------
// ami_in_if: input channel
// One affine transform per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ami_in_if #(
    parameter int WORD_BITS = ami_pkg::WORD_BITS_DEF
) ();
    logic valid;
    logic ready;
    logic signed [WORD_BITS-1:0] in_r0c0, in_r0c1, in_r0c2, in_r0c3;
    logic signed [WORD_BITS-1:0] in_r1c0, in_r1c1, in_r1c2, in_r1c3;
    logic signed [WORD_BITS-1:0] in_r2c0, in_r2c1, in_r2c2, in_r2c3;

    modport source (
        output valid, in_r0c0, in_r0c1, in_r0c2, in_r0c3,
        output in_r1c0, in_r1c1, in_r1c2, in_r1c3,
        output in_r2c0, in_r2c1, in_r2c2, in_r2c3,
        input  ready
    );
    modport sink (
        input  valid, in_r0c0, in_r0c1, in_r0c2, in_r0c3,
        input  in_r1c0, in_r1c1, in_r1c2, in_r1c3,
        input  in_r2c0, in_r2c1, in_r2c2, in_r2c3,
        output ready
    );
endinterface

FILE: hw/rtl/ami_out_if.sv
// ----------------------------------------------------------------------------
// ami_out_if: output channel
// One inverse transform per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ami_out_if #(
    parameter int WORD_BITS = ami_pkg::WORD_BITS_DEF
) ();
    logic valid;
    logic ready;
    logic signed [WORD_BITS-1:0] out_r0c0, out_r0c1, out_r0c2, out_r0c3;
    logic signed [WORD_BITS-1:0] out_r1c0, out_r1c1, out_r1c2, out_r1c3;
    logic signed [WORD_BITS-1:0] out_r2c0, out_r2c1, out_r2c2, out_r2c3;

    modport source (
        output valid, out_r0c0, out_r0c1, out_r0c2, out_r0c3,
        output out_r1c0, out_r1c1, out_r1c2, out_r1c3,
        output out_r2c0, out_r2c1, out_r2c2, out_r2c3,
        input  ready
    );
    modport sink (
        input  valid, out_r0c0, out_r0c1, out_r0c2, out_r0c3,
        input  out_r1c0, out_r1c1, out_r1c2, out_r1c3,
        input  out_r2c0, out_r2c1, out_r2c2, out_r2c3,
        output ready
    );
endinterface

FILE: hw/rtl/affine_matrix_inverse.sv
// ----------------------------------------------------------------------------
// affine_matrix_inverse: 3x4 affine transform inverse, fixed point
// Adjugate over determinant, translation -inv*t, rounded and saturated.
//
// Channel   Dir  Handshake      Word
// i_in      in   valid/ready    twelve transform elements, signed Q16.16
// o_out     out  valid/ready    twelve inverse elements, signed Q16.16
//
// One transform per cycle sustained while the sink takes results. A job
// passes the cofactor pipeline, the queue and the back end, whose depth is
// set by the restoring divider with one quotient bit per stage.
// Reset clears the valid lines and the queue pointers and count only.
// A stalled sink freezes the back end; the front keeps filling the queue
// and then holds i_in.ready low.
// ----------------------------------------------------------------------------
module affine_matrix_inverse #(
    parameter int WORD_BITS = ami_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ami_in_if.sink      i_in,
    ami_out_if.source   o_out
);
    import ami_pkg::*;

    localparam int W        = WORD_BITS;
    localparam int JOB_BITS = 9 * (2 * W + 1) + 3 * (3 * W + 4) + (3 * W + 3) + 1;

    logic signed [W-1:0] m [3][4];
    logic [JOB_BITS-1:0] front_job;
    logic [JOB_BITS-1:0] queue_job;
    logic                front_valid;
    logic                push;
    logic                pop;
    t_queue_stat         stat;
    logic [W-1:0]        res [N_ELEM];

    // unpack the input word
    assign m[0][0] = i_in.in_r0c0;
    assign m[0][1] = i_in.in_r0c1;
    assign m[0][2] = i_in.in_r0c2;
    assign m[0][3] = i_in.in_r0c3;
    assign m[1][0] = i_in.in_r1c0;
    assign m[1][1] = i_in.in_r1c1;
    assign m[1][2] = i_in.in_r1c2;
    assign m[1][3] = i_in.in_r1c3;
    assign m[2][0] = i_in.in_r2c0;
    assign m[2][1] = i_in.in_r2c1;
    assign m[2][2] = i_in.in_r2c2;
    assign m[2][3] = i_in.in_r2c3;

    ami_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_m     (m),
        .o_valid (front_valid),
        .i_ready (~stat.full),
        .o_job   (front_job)
    );

    assign push = front_valid & ~stat.full;

    ami_queue #(
        .JOB_BITS (JOB_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .i_pop   (pop),
        .o_data  (queue_job),
        .o_stat  (stat)
    );

    ami_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (queue_job),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    // pack the output word
    assign o_out.out_r0c0 = res[0];
    assign o_out.out_r0c1 = res[1];
    assign o_out.out_r0c2 = res[2];
    assign o_out.out_r0c3 = res[3];
    assign o_out.out_r1c0 = res[4];
    assign o_out.out_r1c1 = res[5];
    assign o_out.out_r1c2 = res[6];
    assign o_out.out_r1c3 = res[7];
    assign o_out.out_r2c0 = res[8];
    assign o_out.out_r2c1 = res[9];
    assign o_out.out_r2c2 = res[10];
    assign o_out.out_r2c3 = res[11];

endmodule

FILE: hw/rtl/ami_front.sv
// ----------------------------------------------------------------------------
// ami_front: cofactor and determinant pipeline
// Six stages: cofactor products, adjugate, split partial products, term
// assembly, determinant and translation sums, singular flag.
// ----------------------------------------------------------------------------
module ami_front #(
    parameter int WORD_BITS = ami_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [WORD_BITS-1:0] i_m [3][4],
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [9*(2*WORD_BITS+1)+3*(3*WORD_BITS+4)+(3*WORD_BITS+3):0] o_job
);
    import ami_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int PW  = 2 * W;
    localparam int AW  = 2 * W + 1;
    localparam int XW  = 2 * W + 1;
    localparam int TW  = 3 * W + 3;
    localparam int SW  = 3 * W + 4;
    localparam int NST = 6;

    logic [NST-1:0] r_vld;
    logic           en;

    logic signed [PW-1:0] r1_pa [3][3];
    logic signed [PW-1:0] r1_pb [3][3];
    logic signed [W-1:0]  r1_c0 [3];
    logic signed [W-1:0]  r1_t  [3];
    logic signed [AW-1:0] r2_adj [3][3];
    logic signed [W-1:0]  r2_c0 [3];
    logic signed [W-1:0]  r2_t  [3];
    logic signed [XW-1:0] r3_dlo [3];
    logic signed [XW-1:0] r3_dhi [3];
    logic signed [XW-1:0] r3_slo [3][3];
    logic signed [XW-1:0] r3_shi [3][3];
    logic signed [AW-1:0] r3_adj [3][3];
    logic signed [TW-1:0] r4_dterm [3];
    logic signed [TW-1:0] r4_sterm [3][3];
    logic signed [AW-1:0] r4_adj [3][3];
    logic signed [TW-1:0] r5_det;
    logic signed [SW-1:0] r5_s [3];
    logic signed [AW-1:0] r5_adj [3][3];
    logic signed [TW-1:0] r6_det;
    logic signed [SW-1:0] r6_s [3];
    logic signed [AW-1:0] r6_adj [3][3];
    logic                 r6_sing;

    // advance unless the last stage holds a word the queue cannot take
    assign en      = ~r_vld[NST-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    genvar gi, gj;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_row
            for (gj = 0; gj < 3; gj++) begin : g_col
                localparam int J1 = (gj + 1) % 3;
                localparam int J2 = (gj + 2) % 3;
                localparam int I1 = (gi + 1) % 3;
                localparam int I2 = (gi + 2) % 3;

                // cofactor products, then adjugate and the carry line
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r1_pa[gi][gj]  <= i_m[J1][I1] * i_m[J2][I2];
                        r1_pb[gi][gj]  <= i_m[J1][I2] * i_m[J2][I1];
                        r2_adj[gi][gj] <= AW'(r1_pa[gi][gj]) - AW'(r1_pb[gi][gj]);
                        r3_adj[gi][gj] <= r2_adj[gi][gj];
                        r4_adj[gi][gj] <= r3_adj[gi][gj];
                        r5_adj[gi][gj] <= r4_adj[gi][gj];
                        r6_adj[gi][gj] <= r5_adj[gi][gj];
                    end
                end

                // translation partials: adjugate split in low and high halves
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r3_slo[gi][gj] <= r2_t[gj] *
                            $signed({1'b0, r2_adj[gi][gj][W-1:0]});
                        r3_shi[gi][gj] <= r2_t[gj] * $signed(r2_adj[gi][gj][AW-1:W]);
                        r4_sterm[gi][gj] <= (TW'(r3_shi[gi][gj]) << W) +
                            TW'(r3_slo[gi][gj]);
                    end
                end

                assign o_job[(gi*3+gj)*AW +: AW] = r6_adj[gi][gj];
            end

            // first-column carry, determinant partials and sums
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r1_c0[gi]    <= i_m[gi][0];
                    r1_t[gi]     <= i_m[gi][3];
                    r2_c0[gi]    <= r1_c0[gi];
                    r2_t[gi]     <= r1_t[gi];
                    r3_dlo[gi]   <= r2_c0[gi] * $signed({1'b0, r2_adj[0][gi][W-1:0]});
                    r3_dhi[gi]   <= r2_c0[gi] * $signed(r2_adj[0][gi][AW-1:W]);
                    r4_dterm[gi] <= (TW'(r3_dhi[gi]) << W) + TW'(r3_dlo[gi]);
                    r5_s[gi]     <= -(SW'(r4_sterm[gi][0]) + SW'(r4_sterm[gi][1]) +
                                      SW'(r4_sterm[gi][2]));
                    r6_s[gi]     <= r5_s[gi];
                end
            end

            assign o_job[9*AW + gi*SW +: SW] = r6_s[gi];
        end
    endgenerate

    // determinant and its zero test
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_det  <= r4_dterm[0] + r4_dterm[1] + r4_dterm[2];
            r6_det  <= r5_det;
            r6_sing <= (r5_det == '0);
        end
    end

    assign o_job[9*AW + 3*SW +: TW] = r6_det;
    assign o_job[9*AW + 3*SW + TW]  = r6_sing;

endmodule

FILE: hw/rtl/ami_queue.sv
// ----------------------------------------------------------------------------
// ami_queue: short job queue
// Decouples the cofactor front from the divider back.
// ----------------------------------------------------------------------------
module ami_queue #(
    parameter int JOB_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [JOB_BITS-1:0]        i_data,
    input  logic                       i_pop,
    output logic [JOB_BITS-1:0]        o_data,
    output ami_pkg::t_queue_stat       o_stat
);
    import ami_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [JOB_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr;
    logic [PTR_W-1:0]    r_rd;
    logic [CNT_W-1:0]    r_cnt;

    assign o_stat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rd];

    // store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/ami_lane.sv
// ----------------------------------------------------------------------------
// ami_lane: one inverse element
// Forms numerator and denominator and the round-to-nearest operands, then a
// restoring divider with one quotient bit per stage, saturation in the output register.
// ----------------------------------------------------------------------------
module ami_lane #(
    parameter int WORD_BITS = ami_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  ami_pkg::t_lane_ctrl           i_ctrl,
    input  logic signed [3*WORD_BITS+3:0] i_x,
    input  logic signed [3*WORD_BITS+2:0] i_det,
    output logic [WORD_BITS-1:0]          o_res
);
    import ami_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int SW  = 3 * W + 4;
    localparam int TW  = 3 * W + 3;
    localparam int H   = SW / 2;
    localparam int HW  = SW - H;
    localparam int PLW = H + GAIN_BITS;
    localparam int PHW = HW + GAIN_BITS + 1;
    localparam int NW  = 3 * W + GAIN_BITS + 2 * F + 4;
    localparam int EW  = NW + 2;
    localparam int RW  = EW + W;
    localparam int QW  = W + 1;

    logic [PLW-1:0]       r1_plo;
    logic signed [PHW-1:0] r1_phi;
    logic signed [SW-1:0] r1_x;
    logic signed [TW-1:0] r1_det;
    t_lane_ctrl           r1_ctrl;
    logic [NW-1:0]        n_num;
    logic [NW-1:0]        n_den;
    logic [NW-1:0]        r2_n;
    logic [NW-1:0]        r2_d;
    logic [NW-1:0]        r3_an;
    logic [NW-1:0]        r3_ad;
    logic                 r3_neg;
    logic [EW-1:0]        r4_num;
    logic [EW-1:0]        r4_den;
    logic                 r4_neg;

    logic [EW-1:0] w_rem [W+2];
    logic [EW-1:0] w_den [W+2];
    logic [QW-1:0] w_q   [W+2];
    logic          w_neg [W+2];
    logic [EW-1:0] r_rem [W+1];
    logic [EW-1:0] r_den [W+1];
    logic [QW-1:0] r_q   [W+1];
    logic          r_neg [W+1];

    logic [QW-1:0] limit;
    logic [QW-1:0] q_sat;

    // singular gain partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_plo  <= PLW'(i_x[H-1:0]) * PLW'(SINGULAR_GAIN);
            r1_phi  <= $signed(i_x[SW-1:H]) * $signed({1'b0, SINGULAR_GAIN});
            r1_x    <= i_x;
            r1_det  <= i_det;
            r1_ctrl <= i_ctrl;
        end
    end

    // pick scaled numerator and denominator
    always_comb begin
        if (r1_ctrl.singular) begin
            n_num = (NW'(r1_phi) << H) + NW'(r1_plo);
            n_den = r1_ctrl.trans ? (NW'(1) << (2 * F)) : (NW'(1) << F);
        end else begin
            n_num = r1_ctrl.trans ? (NW'(r1_x) << F) : (NW'(r1_x) << (2 * F));
            n_den = NW'(r1_det);
        end
    end

    // magnitudes, then the round-to-nearest operands
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_n   <= n_num;
            r2_d   <= n_den;
            r3_an  <= r2_n[NW-1] ? -r2_n : r2_n;
            r3_ad  <= r2_d[NW-1] ? -r2_d : r2_d;
            r3_neg <= r2_n[NW-1] ^ r2_d[NW-1];
            r4_num <= (EW'(r3_an) << 1) + EW'(r3_ad);
            r4_den <= EW'(r3_ad) << 1;
            r4_neg <= r3_neg;
        end
    end

    assign w_rem[0] = r4_num;
    assign w_den[0] = r4_den;
    assign w_q[0]   = '0;
    assign w_neg[0] = r4_neg;

    genvar gs;
    generate
        for (gs = 0; gs <= W; gs++) begin : g_div
            localparam int K = W - gs;
            logic [RW-1:0] cand;
            logic          ge;

            assign cand = RW'(w_den[gs]) << K;
            assign ge   = (RW'(w_rem[gs]) >= cand);

            // one quotient bit
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[gs] <= ge ? EW'(RW'(w_rem[gs]) - cand) : w_rem[gs];
                    r_den[gs] <= w_den[gs];
                    r_q[gs]   <= ge ? (w_q[gs] | (QW'(1) << K)) : w_q[gs];
                    r_neg[gs] <= w_neg[gs];
                end
            end

            assign w_rem[gs+1] = r_rem[gs];
            assign w_den[gs+1] = r_den[gs];
            assign w_q[gs+1]   = r_q[gs];
            assign w_neg[gs+1] = r_neg[gs];
        end
    endgenerate

    // saturate to the signed word range and apply the sign
    assign limit = w_neg[W+1] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - 1'b1);
    assign q_sat = (w_q[W+1] > limit) ? limit : w_q[W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= W'(w_neg[W+1] ? -q_sat : q_sat);
        end
    end

    // final remainder is not needed past the last stage
    logic unused_rem;
    assign unused_rem = ^w_rem[W+1] ^ ^w_den[W+1];

endmodule

FILE: hw/rtl/ami_back.sv
// ----------------------------------------------------------------------------
// ami_back: divider back end
// Twelve lanes share one valid line; pops a job when the pipe advances and the queue is not empty.
// ----------------------------------------------------------------------------
module ami_back #(
    parameter int WORD_BITS = ami_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [9*(2*WORD_BITS+1)+3*(3*WORD_BITS+4)+(3*WORD_BITS+3):0] i_job,
    input  ami_pkg::t_queue_stat   i_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [WORD_BITS-1:0]   o_res [ami_pkg::N_ELEM]
);
    import ami_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int AW  = 2 * W + 1;
    localparam int TW  = 3 * W + 3;
    localparam int SW  = 3 * W + 4;
    localparam int LAT = W + 6;

    logic [LAT-1:0] r_vld;
    logic           en;

    // advance unless a finished word waits on a stalled sink
    assign en      = ~r_vld[LAT-1] | i_ready;
    assign o_pop   = en & ~i_stat.empty;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], o_pop};
        end
    end

    genvar ge;
    generate
        for (ge = 0; ge < N_ELEM; ge++) begin : g_lane
            localparam int R = ge / 4;
            localparam int C = ge % 4;
            logic signed [SW-1:0] x;
            t_lane_ctrl           ctrl;

            if (C == 3) begin : g_trans
                assign x = i_job[9*AW + R*SW +: SW];
            end else begin : g_lin
                assign x = SW'($signed(i_job[(R*3+C)*AW +: AW]));
            end

            assign ctrl.singular = i_job[9*AW + 3*SW + TW];
            assign ctrl.trans    = (C == 3);

            ami_lane #(
                .WORD_BITS (WORD_BITS),
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_ctrl (ctrl),
                .i_x    (x),
                .i_det  (i_job[9*AW + 3*SW +: TW]),
                .o_res  (o_res[ge])
            );
        end
    endgenerate

endmodule
